// ===== design/sib_pkg.sv =====
// Shared types and constants for the sorted insertion buffer.
`timescale 1ns / 1ps
`default_nettype none
package sib_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DRAIN  = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic signed [KEY_W-1:0] key;
  } sib_in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] value;
    logic                    last;
    logic                    empty_res;
    logic                    overflow;
  } sib_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } sib_state_e;

  typedef struct packed {
    logic insert;
    logic drain_go;
    logic step;
  } sib_cmd_t;

  typedef struct packed {
    logic last;
  } sib_sts_t;

endpackage
`default_nettype wire

// ===== design/sorted_insertion_buffer.sv =====
// Top level of the sorted insertion buffer.
//
//   channel  | handshake        | word
//   ---------+------------------+-----------------------------------
//   input    | start, busy      | in_i  : kind, key
//   result   | valid_o          | res_o : value, last, empty_res, overflow
//
// On an insert the whole key array compares and shifts at once,
// and busy stays low, so inserts may follow every cycle.
// A drain holds busy high while it presents each stored key in turn (a single
// empty word when empty), shifting the array down toward the head that feeds res_o.
// Reset clears the fill count, the overflow flag and the state; key
// registers hold no reset value. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none
module sorted_insertion_buffer
  import sib_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  input  wire sib_in_t in_i,
  output logic         busy,
  output logic         valid_o,
  output sib_out_t     res_o
);

  sib_cmd_t cmd;
  sib_sts_t sts;

  sib_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (in_i.kind),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .valid_o (valid_o)
  );

  sib_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .in_i   (in_i),
    .sts_o  (sts),
    .res_o  (res_o)
  );

`ifndef SYNTH
  a_valid_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy)
    else $error("result strobe outside a drain");

  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.last) |=> !busy)
    else $error("drain did not end after last word");

  a_empty_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.empty_res) |-> (res_o.last && (res_o.value == '0)))
    else $error("empty drain word malformed");

  a_drain_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (in_i.kind == KIND_DRAIN)) |=> valid_o)
    else $error("drain accepted without result");
`endif

endmodule
`default_nettype wire

// ===== design/sib_datapath.sv =====
// Compare-and-shift key array, fill count and overflow flag.
`timescale 1ns / 1ps
`default_nettype none
module sib_datapath
  import sib_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire sib_cmd_t cmd_i,
  input  wire sib_in_t  in_i,
  output sib_sts_t      sts_o,
  output sib_out_t      res_o
);

  logic [KEY_W-1:0] keys_q [CAPACITY];
  logic [KEY_W-1:0] keys_d [CAPACITY];
  logic [CNT_W-1:0] count_q, count_d;
  logic             flag_q, flag_d;
  logic             empty_q, empty_d;
  logic [CAPACITY-1:0] lt;
  logic             full;
  logic             last;

  assign full = (count_q == CNT_W'(CAPACITY));
  assign last = empty_q || (count_q == CNT_W'(1));

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i] = (CNT_W'(i) < count_q) && ($signed(keys_q[i]) < $signed(in_i.key));
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      keys_d[i] = keys_q[i];
    end
    if (cmd_i.insert && !full) begin
      if (!lt[0]) begin
        keys_d[0] = in_i.key;
      end
      for (int i = 1; i < CAPACITY; i++) begin
        if (!lt[i]) begin
          keys_d[i] = lt[i-1] ? in_i.key : keys_q[i-1];
        end
      end
    end else if (cmd_i.step) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        keys_d[i] = keys_q[i+1];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    flag_d  = flag_q;
    empty_d = empty_q;
    if (cmd_i.insert) begin
      if (full) begin
        flag_d = 1'b1;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else if (cmd_i.drain_go) begin
      empty_d = (count_q == '0);
    end else if (cmd_i.step) begin
      if (last) begin
        count_d = '0;
        flag_d  = 1'b0;
        empty_d = 1'b0;
      end else begin
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      keys_q[i] <= keys_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      flag_q  <= 1'b0;
      empty_q <= 1'b0;
    end else begin
      count_q <= count_d;
      flag_q  <= flag_d;
      empty_q <= empty_d;
    end
  end

  assign sts_o.last      = last;
  assign res_o.value     = empty_q ? '0 : keys_q[0];
  assign res_o.last      = last;
  assign res_o.empty_res = empty_q;
  assign res_o.overflow  = flag_q;

endmodule
`default_nettype wire

// ===== design/sib_ctrl.sv =====
// Control state machine: accept words, sequence a drain.
`timescale 1ns / 1ps
`default_nettype none
module sib_ctrl
  import sib_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire logic     kind_i,
  input  wire sib_sts_t sts_i,
  output sib_cmd_t      cmd_o,
  output logic          busy_o,
  output logic          valid_o
);

  sib_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i && (kind_i == KIND_DRAIN)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o   = '0;
    busy_o  = 1'b0;
    valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.insert   = start_i && (kind_i == KIND_INSERT);
        cmd_o.drain_go = start_i && (kind_i == KIND_DRAIN);
      end
      ST_DRAIN: begin
        cmd_o.step = 1'b1;
        busy_o     = 1'b1;
        valid_o    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire
